/* rtl/core/mbup_pkg.sv */
package mbup_pkg;

   // MIDI status codes
   localparam logic [7:0] MIDI_SYSEX_START  = 8'hf0;
   localparam logic [7:0] MIDI_MTC_QUARTER  = 8'hf1;
   localparam logic [7:0] MIDI_SONG_POS     = 8'hf2;
   localparam logic [7:0] MIDI_SONG_SELECT  = 8'hf3;
   localparam logic [7:0] MIDI_TUNE_REQUEST = 8'hf6;
   localparam logic [7:0] MIDI_SYSEX_END    = 8'hf7;

   localparam logic [3:0] MIDI_SYSTEM_NIBBLE = 4'hf;
   localparam logic [4:0] MIDI_REALTIME_TOP  = 5'b11111;
   localparam logic [2:0] MIDI_ONE_PARAM_TOP = 3'b110;

   // USB-MIDI code index numbers
   localparam logic [3:0] CIN_COMMON_TWO   = 4'h2;
   localparam logic [3:0] CIN_COMMON_THREE = 4'h3;
   localparam logic [3:0] CIN_SYSEX_CONT   = 4'h4;
   localparam logic [3:0] CIN_END_ONE      = 4'h5;
   localparam logic [3:0] CIN_END_TWO      = 4'h6;
   localparam logic [3:0] CIN_END_THREE    = 4'h7;
   localparam logic [3:0] CIN_SINGLE_BYTE  = 4'hf;

   typedef struct packed {
      logic [7:0] usb_header;
      logic [7:0] packet_byte_1;
      logic [7:0] packet_byte_2;
      logic [7:0] packet_byte_3;
      logic [1:0] message_length;
   } packet_type;

   function automatic logic [1:0] cin_length(input logic [3:0] cin);
      logic [1:0] len;
      case (cin)
         4'h0, 4'h1:                      len = 2'd0;
         4'h5, 4'hf:                      len = 2'd1;
         4'h2, 4'h6, 4'hc, 4'hd:          len = 2'd2;
         default:                         len = 2'd3;
      endcase
      return len;
   endfunction

endpackage

/* rtl/core/mbup_parser.sv */
module mbup_parser
   import mbup_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] cable_number,
   input  logic       byte_valid,
   input  logic [7:0] midi_byte,
   output logic       packet_valid,
   output packet_type packet
);

   typedef enum logic [6:0] {
      PS_SCAN  = 7'b0000001,
      PS_ONE   = 7'b0000010,
      PS_TWO_A = 7'b0000100,
      PS_TWO_B = 7'b0001000,
      PS_SX0   = 7'b0010000,
      PS_SX1   = 7'b0100000,
      PS_SX2   = 7'b1000000
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [7:0] held_status_ff, held_status_in;
   logic [7:0] held_data_ff, held_data_in;
   logic [3:0] cin;
   logic [7:0] b1, b2, b3;

   always_comb begin
      state_in       = state_ff;
      held_status_in = held_status_ff;
      held_data_in   = held_data_ff;
      packet_valid   = 1'b0;
      cin            = CIN_SINGLE_BYTE;
      b1             = midi_byte;
      b2             = 8'h00;
      b3             = 8'h00;

      if (midi_byte[7:3] == MIDI_REALTIME_TOP) begin
         // real-time bytes pass straight through, parse untouched
         packet_valid = 1'b1;
      end else if (midi_byte[7:4] == MIDI_SYSTEM_NIBBLE) begin
         case (midi_byte) inside
            MIDI_SYSEX_START: begin
               held_status_in = midi_byte;
               state_in       = PS_SX1;
            end
            MIDI_MTC_QUARTER, MIDI_SONG_SELECT: begin
               held_status_in = midi_byte;
               state_in       = PS_ONE;
            end
            MIDI_SONG_POS: begin
               held_status_in = midi_byte;
               state_in       = PS_TWO_A;
            end
            MIDI_TUNE_REQUEST: begin
               held_status_in = midi_byte;
               held_data_in   = 8'h00;
               state_in       = PS_SCAN;
               packet_valid   = 1'b1;
               cin            = CIN_END_ONE;
            end
            MIDI_SYSEX_END: begin
               state_in = PS_SCAN;
               unique case (state_ff)
                  PS_SX0: begin
                     held_status_in = midi_byte;
                     held_data_in   = 8'h00;
                     packet_valid   = 1'b1;
                     cin            = CIN_END_ONE;
                  end
                  PS_SX1: begin
                     held_data_in = midi_byte;
                     packet_valid = 1'b1;
                     cin          = CIN_END_TWO;
                     b1           = held_status_ff;
                     b2           = midi_byte;
                  end
                  PS_SX2: begin
                     packet_valid = 1'b1;
                     cin          = CIN_END_THREE;
                     b1           = held_status_ff;
                     b2           = held_data_ff;
                     b3           = midi_byte;
                  end
                  default: begin
                     // end of sysex outside sysex: drop
                  end
               endcase
            end
            default: begin
               state_in = PS_SCAN;
            end
         endcase
      end else if (midi_byte[7]) begin
         held_status_in = midi_byte;
         state_in = (midi_byte[7:5] == MIDI_ONE_PARAM_TOP) ? PS_ONE : PS_TWO_A;
      end else begin
         unique case (state_ff)
            PS_ONE: begin
               if (held_status_ff[7:4] != MIDI_SYSTEM_NIBBLE) begin
                  cin = held_status_ff[7:4];
               end else begin
                  cin      = CIN_COMMON_TWO;
                  state_in = PS_SCAN;
               end
               held_data_in = midi_byte;
               packet_valid = 1'b1;
               b1           = held_status_ff;
               b2           = midi_byte;
            end
            PS_TWO_A: begin
               held_data_in = midi_byte;
               state_in     = PS_TWO_B;
            end
            PS_TWO_B: begin
               // running status rearms for the next pair
               if (held_status_ff[7:4] != MIDI_SYSTEM_NIBBLE) begin
                  cin      = held_status_ff[7:4];
                  state_in = PS_TWO_A;
               end else begin
                  cin      = CIN_COMMON_THREE;
                  state_in = PS_SCAN;
               end
               packet_valid = 1'b1;
               b1           = held_status_ff;
               b2           = held_data_ff;
               b3           = midi_byte;
            end
            PS_SX0: begin
               held_status_in = midi_byte;
               state_in       = PS_SX1;
            end
            PS_SX1: begin
               held_data_in = midi_byte;
               state_in     = PS_SX2;
            end
            PS_SX2: begin
               state_in     = PS_SX0;
               packet_valid = 1'b1;
               cin          = CIN_SYSEX_CONT;
               b1           = held_status_ff;
               b2           = held_data_ff;
               b3           = midi_byte;
            end
            default: begin
               // data while scanning: drop
            end
         endcase
      end
   end

   assign packet.usb_header     = {cable_number, cin};
   assign packet.packet_byte_1  = b1;
   assign packet.packet_byte_2  = b2;
   assign packet.packet_byte_3  = b3;
   assign packet.message_length = cin_length(cin);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PS_SCAN;
         held_status_ff <= 8'h00;
         held_data_ff   <= 8'h00;
      end else if (byte_valid) begin
         state_ff       <= state_in;
         held_status_ff <= held_status_in;
         held_data_ff   <= held_data_in;
      end
   end

endmodule

/* rtl/core/midi_byte_to_usb_midi_packet_unit.sv */
// MIDI byte stream to USB-MIDI event packet converter.
// Request channel (req_valid/req_ready/req_midi_byte) takes one raw MIDI byte
// per transfer. Response channel (rsp_valid/rsp_ready and the rsp_ payload)
// gives one 4-byte event packet whenever a byte completes a message: header
// with cable number and code index, three MIDI bytes and the valid byte count.
// Bytes that complete nothing produce no response.
// csr_write_enable/csr_write_data set the cable number; write only while idle.
// A packet is registered in the output register, or in the skid register while
// the output register is held, once its last byte is transferred. One byte per
// cycle while req_ready is high, set by single-pass next-state parser logic.
// A two-deep output stage (output register plus skid register) decouples the
// channels: while the receiver stalls, bytes are still taken until one more
// packet is held; req_ready drops only when both entries hold packets, and
// rises the cycle after the output register drains.
// Reset (synchronous, active high) clears the parser to scanning for status,
// empties the output stage and sets the cable number to zero.
module midi_byte_to_usb_midi_packet_unit
   import mbup_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_midi_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_usb_header,
   output logic [7:0] rsp_packet_byte_1,
   output logic [7:0] rsp_packet_byte_2,
   output logic [7:0] rsp_packet_byte_3,
   output logic [1:0] rsp_message_length
);

   logic [3:0] cable_ff;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       push;
   packet_type new_packet;

   logic       out_valid_ff, out_valid_in;
   packet_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   packet_type skid_ff, skid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cable_ff <= 4'h0;
      end else if (csr_write_enable) begin
         cable_ff <= csr_write_data;
      end
   end

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = out_valid_ff && rsp_ready;

   mbup_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cable_number (cable_ff),
      .byte_valid   (req_xfer),
      .midi_byte    (req_midi_byte),
      .packet_valid (push),
      .packet       (new_packet)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_xfer) begin
         // advance the skid entry into the output register
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_xfer && push) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = new_packet;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = new_packet;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_usb_header     = out_ff.usb_header;
   assign rsp_packet_byte_1  = out_ff.packet_byte_1;
   assign rsp_packet_byte_2  = out_ff.packet_byte_2;
   assign rsp_packet_byte_3  = out_ff.packet_byte_3;
   assign rsp_message_length = out_ff.message_length;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_realtime_emits : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_midi_byte[7:3] == MIDI_REALTIME_TOP) |=> rsp_valid)
      else $error("real-time byte produced no packet");

   a_length_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_message_length != 2'd0))
      else $error("packet with zero MIDI byte count");

endmodule
